// ----- hdl/frustum_cull_classify_assert.svh -----
// Assertion macros for the frustum cull classifier.
`ifndef FRUSTUM_CULL_CLASSIFY_ASSERT_SVH
`define FRUSTUM_CULL_CLASSIFY_ASSERT_SVH
`ifndef SYNTHESIS
`define FCC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FCC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define FCC_ASSERT(lbl, clk, rst_n, prop, msg)
`define FCC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ----- hdl/fcc_pkg.sv -----
// Shared types and constants of the frustum cull classifier.
package fcc_pkg;

    localparam int PLANE_COUNT_DEF = 6;
    localparam int COORD_WIDTH_DEF = 16;
    localparam int PLANE_MAX       = 6;
    localparam int COEF_WIDTH      = 16;
    localparam int FRAC_SHIFT      = 14;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 4 * COEF_WIDTH;

    typedef enum logic [1:0] {
        CLS_INSIDE     = 2'd0,
        CLS_INTERSECTS = 2'd1,
        CLS_OUTSIDE    = 2'd2
    } t_cull_class;

    // a in the low bits, d in the high bits
    typedef struct packed {
        logic signed [COEF_WIDTH-1:0] d;
        logic signed [COEF_WIDTH-1:0] c;
        logic signed [COEF_WIDTH-1:0] b;
        logic signed [COEF_WIDTH-1:0] a;
    } t_plane;

    typedef struct packed {
        logic en;
        logic sphere;
    } t_cls_ctl;

endpackage

// ----- hdl/fcc_req_if.sv -----
// Request channel carrying one box or sphere.
interface fcc_req_if import fcc_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic                          opcode;
    logic signed [COORD_WIDTH-1:0] min_x;
    logic signed [COORD_WIDTH-1:0] min_y;
    logic signed [COORD_WIDTH-1:0] min_z;
    logic signed [COORD_WIDTH-1:0] max_x;
    logic signed [COORD_WIDTH-1:0] max_y;
    logic signed [COORD_WIDTH-1:0] max_z;
    logic signed [COORD_WIDTH-1:0] center_x;
    logic signed [COORD_WIDTH-1:0] center_y;
    logic signed [COORD_WIDTH-1:0] center_z;
    logic        [COORD_WIDTH-2:0] radius;

    modport source (
        output valid, opcode, min_x, min_y, min_z, max_x, max_y, max_z,
               center_x, center_y, center_z, radius,
        input  ready
    );
    modport sink (
        input  valid, opcode, min_x, min_y, min_z, max_x, max_y, max_z,
               center_x, center_y, center_z, radius,
        output ready
    );
endinterface

// ----- hdl/fcc_rsp_if.sv -----
// Response channel carrying the cull class.
interface fcc_rsp_if import fcc_pkg::*; ();
    logic        valid;
    logic        ready;
    t_cull_class cull_class;

    modport source (output valid, cull_class, input ready);
    modport sink   (input valid, cull_class, output ready);
endinterface

// ----- hdl/fcc_plane_lane.sv -----
// One plane lane: six products, then min and max distance over the box corners.
module fcc_plane_lane import fcc_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int DIST_W      = COEF_WIDTH + COORD_WIDTH + 2
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  t_plane                        i_plane,
    input  logic signed [COORD_WIDTH-1:0] i_lo_x,
    input  logic signed [COORD_WIDTH-1:0] i_lo_y,
    input  logic signed [COORD_WIDTH-1:0] i_lo_z,
    input  logic signed [COORD_WIDTH-1:0] i_hi_x,
    input  logic signed [COORD_WIDTH-1:0] i_hi_y,
    input  logic signed [COORD_WIDTH-1:0] i_hi_z,
    output logic signed [DIST_W-1:0]      o_dmin,
    output logic signed [DIST_W-1:0]      o_dmax
);
    localparam int PROD_W = COEF_WIDTH + COORD_WIDTH;

    logic signed [PROD_W-1:0]     r_ax_lo, r_ax_hi, r_by_lo, r_by_hi, r_cz_lo, r_cz_hi;
    logic signed [COEF_WIDTH-1:0] r_d;
    logic signed [PROD_W-1:0]     w_ax_min, w_ax_max, w_by_min, w_by_max, w_cz_min, w_cz_max;
    logic signed [DIST_W-1:0]     w_d_ext;
    logic signed [DIST_W-1:0]     r_dmin, r_dmax;

    // products stage
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ax_lo <= i_plane.a * i_lo_x;
            r_ax_hi <= i_plane.a * i_hi_x;
            r_by_lo <= i_plane.b * i_lo_y;
            r_by_hi <= i_plane.b * i_hi_y;
            r_cz_lo <= i_plane.c * i_lo_z;
            r_cz_hi <= i_plane.c * i_hi_z;
            r_d     <= i_plane.d;
        end
    end

    // the distance is separable per axis, so the extreme corners come from per-axis extremes
    always_comb begin
        w_ax_max = (r_ax_hi > r_ax_lo) ? r_ax_hi : r_ax_lo;
        w_ax_min = (r_ax_hi > r_ax_lo) ? r_ax_lo : r_ax_hi;
        w_by_max = (r_by_hi > r_by_lo) ? r_by_hi : r_by_lo;
        w_by_min = (r_by_hi > r_by_lo) ? r_by_lo : r_by_hi;
        w_cz_max = (r_cz_hi > r_cz_lo) ? r_cz_hi : r_cz_lo;
        w_cz_min = (r_cz_hi > r_cz_lo) ? r_cz_lo : r_cz_hi;
        w_d_ext  = {{(DIST_W-COEF_WIDTH-FRAC_SHIFT){r_d[COEF_WIDTH-1]}}, r_d,
                    {FRAC_SHIFT{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dmin <= DIST_W'(w_ax_min) + DIST_W'(w_by_min) + DIST_W'(w_cz_min) + w_d_ext;
            r_dmax <= DIST_W'(w_ax_max) + DIST_W'(w_by_max) + DIST_W'(w_cz_max) + w_d_ext;
        end
    end

    assign o_dmin = r_dmin;
    assign o_dmax = r_dmax;
endmodule

// ----- hdl/fcc_class.sv -----
// Per-plane test flags and the final inside / intersects / outside decision.
module fcc_class import fcc_pkg::*; #(
    parameter int PLANE_COUNT = PLANE_COUNT_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int DIST_W      = COEF_WIDTH + COORD_WIDTH + 2
) (
    input  logic                          i_clk,
    input  t_cls_ctl                      i_ctl,
    input  logic signed [DIST_W-1:0]      i_dmin [PLANE_COUNT],
    input  logic signed [DIST_W-1:0]      i_dmax [PLANE_COUNT],
    input  logic        [COORD_WIDTH-2:0] i_rad,
    output t_cull_class                   o_class
);
    logic signed [DIST_W-1:0] w_r, w_nr;
    logic [PLANE_COUNT-1:0]   n_fail, n_part;
    logic [PLANE_COUNT-1:0]   r_fail, r_part;
    t_cull_class              r_class;

    // for a sphere the lane sees lo == hi, so dmin == dmax is the center distance
    always_comb begin
        w_r  = {{(DIST_W-(COORD_WIDTH-1)-FRAC_SHIFT){1'b0}}, i_rad, {FRAC_SHIFT{1'b0}}};
        w_nr = -w_r;
        for (int i = 0; i < PLANE_COUNT; i++) begin
            if (i_ctl.sphere) begin
                n_fail[i] = i_dmin[i] < w_nr;
                n_part[i] = (i_dmin[i] > w_nr) && (i_dmin[i] < w_r);
            end else begin
                n_fail[i] = i_dmax[i] < 0;
                n_part[i] = i_dmin[i] < 0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_fail <= n_fail;
            r_part <= n_part;
            priority if (|r_fail) begin
                r_class <= CLS_OUTSIDE;
            end else if (|r_part) begin
                r_class <= CLS_INTERSECTS;
            end else begin
                r_class <= CLS_INSIDE;
            end
        end
    end

    assign o_class = r_class;
endmodule

// ----- hdl/frustum_cull_classify.sv -----
// Frustum cull classifier: box or sphere against up to six planes, one request per cycle.
// Registered stages from request to response: input, products, distances, flags, class.
// Throughput one request per cycle; the whole pipeline holds while the response is stalled.
// Synchronous active-low reset clears the valid pipeline and the plane registers to zero.
`include "frustum_cull_classify_assert.svh"

module frustum_cull_classify import fcc_pkg::*; #(
    parameter int PLANE_COUNT = PLANE_COUNT_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    fcc_req_if.sink               i_req,
    fcc_rsp_if.source             o_rsp
);
    localparam int PROD_W   = COEF_WIDTH + COORD_WIDTH;
    localparam int D_TERM_W = COEF_WIDTH + FRAC_SHIFT;
    localparam int DIST_W   = ((PROD_W > D_TERM_W) ? PROD_W : D_TERM_W) + 2;

    t_plane                          r_plane [PLANE_COUNT];
    logic [5:1]                      r_vld;
    logic                            w_en;
    logic signed [COORD_WIDTH-1:0]   r_lo_x, r_lo_y, r_lo_z, r_hi_x, r_hi_y, r_hi_z;
    logic [3:1]                      r_sph;
    logic [COORD_WIDTH-2:0]          r_rad1, r_rad2, r_rad3;
    logic signed [DIST_W-1:0]        w_dmin [PLANE_COUNT];
    logic signed [DIST_W-1:0]        w_dmax [PLANE_COUNT];
    t_cls_ctl                        w_ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < PLANE_COUNT; k++) begin
                r_plane[k] <= '0;
            end
        end else if (i_cfg_we) begin
            for (int k = 0; k < PLANE_COUNT; k++) begin
                if (i_cfg_idx == CFG_IDX_W'(k)) begin
                    r_plane[k] <= i_cfg_wdata;
                end
            end
        end
    end

    // whole pipeline advances together unless the response register is full and stalled
    assign w_en        = !r_vld[5] || o_rsp.ready;
    assign i_req.ready = w_en;
    assign o_rsp.valid = r_vld[5];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[4:1], i_req.valid};
        end
    end

    // input stage: a sphere is fed as a degenerate box at its center
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_lo_x <= i_req.opcode ? i_req.center_x : i_req.min_x;
            r_lo_y <= i_req.opcode ? i_req.center_y : i_req.min_y;
            r_lo_z <= i_req.opcode ? i_req.center_z : i_req.min_z;
            r_hi_x <= i_req.opcode ? i_req.center_x : i_req.max_x;
            r_hi_y <= i_req.opcode ? i_req.center_y : i_req.max_y;
            r_hi_z <= i_req.opcode ? i_req.center_z : i_req.max_z;
            r_sph  <= {r_sph[2:1], i_req.opcode};
            r_rad1 <= i_req.radius;
            r_rad2 <= r_rad1;
            r_rad3 <= r_rad2;
        end
    end

    for (genvar g = 0; g < PLANE_COUNT; g++) begin : g_lane
        fcc_plane_lane #(
            .COORD_WIDTH (COORD_WIDTH),
            .DIST_W      (DIST_W)
        ) u_lane (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_plane (r_plane[g]),
            .i_lo_x  (r_lo_x),
            .i_lo_y  (r_lo_y),
            .i_lo_z  (r_lo_z),
            .i_hi_x  (r_hi_x),
            .i_hi_y  (r_hi_y),
            .i_hi_z  (r_hi_z),
            .o_dmin  (w_dmin[g]),
            .o_dmax  (w_dmax[g])
        );
    end

    assign w_ctl = '{en: w_en, sphere: r_sph[3]};

    fcc_class #(
        .PLANE_COUNT (PLANE_COUNT),
        .COORD_WIDTH (COORD_WIDTH),
        .DIST_W      (DIST_W)
    ) u_class (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_dmin  (w_dmin),
        .i_dmax  (w_dmax),
        .i_rad   (r_rad3),
        .o_class (o_rsp.cull_class)
    );

    `FCC_ASSERT(a_req_enters, i_clk, i_rst_n, w_en && i_req.valid |=> r_vld[1], "request lost at entry")
    `FCC_ASSERT(a_stall_holds, i_clk, i_rst_n, !w_en |=> $stable(r_vld), "pipeline moved while stalled")
    `FCC_ASSERT(a_flags_advance, i_clk, i_rst_n, w_en && r_vld[3] |=> r_vld[4], "item dropped mid pipe")
endmodule
